// File: sv/cda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_pkg: shared types, constants and calendar helpers
// Microcode program, control/status structs and month-length logic for the
// calendar date/time adder.
// ----------------------------------------------------------------------------
package cda_pkg;

   // field widths
   localparam int YEAR_W = 16;
   localparam int AMT_W  = 16;
   localparam int MON_W  = 4;
   localparam int DAY_W  = 5;
   localparam int HR_W   = 5;
   localparam int MIN_W  = 6;
   localparam int SEC_W  = 6;

   localparam int DEF_AMOUNT_BITS = 16;

   // working sum: a field plus a full amount
   localparam int T_W     = AMT_W + 1;
   // reciprocal divide: q = (t * floor(2^FRAC_W / d)) >> FRAC_W, then one fixup
   localparam int FRAC_W  = 22;
   localparam int RECIP_W = 19;
   localparam int PROD_W  = T_W + RECIP_W;
   localparam int Q_W     = PROD_W - FRAC_W;

   localparam logic [RECIP_W-1:0] RECIP_60 = RECIP_W'((64'd1 << FRAC_W) / 60);
   localparam logic [RECIP_W-1:0] RECIP_24 = RECIP_W'((64'd1 << FRAC_W) / 24);
   localparam logic [RECIP_W-1:0] RECIP_12 = RECIP_W'((64'd1 << FRAC_W) / 12);

   localparam logic [T_W-1:0] SECS_PER_MIN = T_W'(60);
   localparam logic [T_W-1:0] HRS_PER_DAY  = T_W'(24);
   localparam logic [T_W-1:0] MONS_PER_YR  = T_W'(12);

   // divisibility by 25 of year/4: multiply by inverse of 25 mod 2^14
   localparam int QY_W = YEAR_W - 2;
   localparam logic [QY_W-1:0] INV25     = QY_W'(7209);
   localparam logic [QY_W-1:0] DIV25_MAX = QY_W'(((1 << QY_W) - 1) / 25);

   // unit codes
   localparam logic [2:0] UNIT_SEC   = 3'd0;
   localparam logic [2:0] UNIT_MIN   = 3'd1;
   localparam logic [2:0] UNIT_HOUR  = 3'd2;
   localparam logic [2:0] UNIT_DAY   = 3'd3;
   localparam logic [2:0] UNIT_MONTH = 3'd4;

   // month codes used by the length lookup
   localparam logic [MON_W-1:0] MON_JAN = 4'd1;
   localparam logic [MON_W-1:0] MON_FEB = 4'd2;
   localparam logic [MON_W-1:0] MON_APR = 4'd4;
   localparam logic [MON_W-1:0] MON_JUN = 4'd6;
   localparam logic [MON_W-1:0] MON_SEP = 4'd9;
   localparam logic [MON_W-1:0] MON_NOV = 4'd11;
   localparam logic [MON_W-1:0] MON_DEC = 4'd12;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_CLAMP,
      OP_MUL,
      OP_DIV,
      OP_DAYS,
      OP_WALK,
      OP_DONE
   } op_type;

   typedef enum logic [1:0] {
      FLD_SEC,
      FLD_MIN,
      FLD_HOUR,
      FLD_MON
   } fld_type;

   localparam int PC_W = 4;

   // program steps
   localparam logic [PC_W-1:0] S_CLAMP_IN = 4'd0;
   localparam logic [PC_W-1:0] S_MUL_SEC  = 4'd1;
   localparam logic [PC_W-1:0] S_DIV_SEC  = 4'd2;
   localparam logic [PC_W-1:0] S_MUL_MIN  = 4'd3;
   localparam logic [PC_W-1:0] S_DIV_MIN  = 4'd4;
   localparam logic [PC_W-1:0] S_MUL_HOUR = 4'd5;
   localparam logic [PC_W-1:0] S_DIV_HOUR = 4'd6;
   localparam logic [PC_W-1:0] S_DAYS     = 4'd7;
   localparam logic [PC_W-1:0] S_WALK     = 4'd8;
   localparam logic [PC_W-1:0] S_MUL_MON  = 4'd9;
   localparam logic [PC_W-1:0] S_DIV_MON  = 4'd10;
   localparam logic [PC_W-1:0] S_SETTLE   = 4'd11;
   localparam logic [PC_W-1:0] S_CLAMP    = 4'd12;
   localparam logic [PC_W-1:0] S_DONE     = 4'd13;

   typedef struct packed {
      op_type          op;
      fld_type         fld;
      logic            jmp;     // jump to target while the day carry is nonzero
      logic [PC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic    load;
      op_type  op;
      fld_type fld;
   } cda_ctrl_type;

   typedef struct packed {
      logic carry_nz;
   } cda_stat_type;

   function automatic ucode_type uword(input op_type op, input fld_type fld,
                                       input logic jmp, input logic [PC_W-1:0] target);
      ucode_type w;
      w.op     = op;
      w.fld    = fld;
      w.jmp    = jmp;
      w.target = target;
      return w;
   endfunction

   // control store
   function automatic ucode_type ucode(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         S_CLAMP_IN: w = uword(OP_CLAMP, FLD_SEC,  1'b0, S_CLAMP_IN);
         S_MUL_SEC:  w = uword(OP_MUL,   FLD_SEC,  1'b0, S_CLAMP_IN);
         S_DIV_SEC:  w = uword(OP_DIV,   FLD_SEC,  1'b0, S_CLAMP_IN);
         S_MUL_MIN:  w = uword(OP_MUL,   FLD_MIN,  1'b0, S_CLAMP_IN);
         S_DIV_MIN:  w = uword(OP_DIV,   FLD_MIN,  1'b0, S_CLAMP_IN);
         S_MUL_HOUR: w = uword(OP_MUL,   FLD_HOUR, 1'b0, S_CLAMP_IN);
         S_DIV_HOUR: w = uword(OP_DIV,   FLD_HOUR, 1'b0, S_CLAMP_IN);
         S_DAYS:     w = uword(OP_DAYS,  FLD_SEC,  1'b0, S_CLAMP_IN);
         S_WALK:     w = uword(OP_WALK,  FLD_SEC,  1'b1, S_WALK);
         S_MUL_MON:  w = uword(OP_MUL,   FLD_MON,  1'b0, S_CLAMP_IN);
         S_DIV_MON:  w = uword(OP_DIV,   FLD_MON,  1'b0, S_CLAMP_IN);
         S_SETTLE:   w = uword(OP_NOP,   FLD_SEC,  1'b0, S_CLAMP_IN);
         S_CLAMP:    w = uword(OP_CLAMP, FLD_SEC,  1'b0, S_CLAMP_IN);
         default:    w = uword(OP_DONE,  FLD_SEC,  1'b0, S_CLAMP_IN);
      endcase
      return w;
   endfunction

   // Gregorian leap rule: /4, except /100 unless /400
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [QY_W-1:0] p;
      logic            d25;
      p   = QY_W'(y[YEAR_W-1:2] * INV25);
      d25 = (p <= DIV25_MAX);
      return (y[1:0] == 2'd0) && (!d25 || (y[3:2] == 2'd0));
   endfunction

   function automatic logic [DAY_W-1:0] mon_len(input logic [MON_W-1:0] m, input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         MON_FEB:                           len = leap ? 5'd29 : 5'd28;
         MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
         default:                           len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// File: sv/cda_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_seq: microcode sequencer
// Step counter over the control store, busy flag, loop on the day walk and
// the result strobe.
// ----------------------------------------------------------------------------
module cda_seq import cda_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  cda_stat_type stat,
   output logic         busy,
   output logic         done,
   output cda_ctrl_type ctrl
);

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic            accept;
   ucode_type       word;

   assign accept = start && !busy_ff;
   assign word   = ucode(pc_ff);

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (accept) begin
         pc_in   = S_CLAMP_IN;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (word.op == OP_DONE) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (word.jmp && stat.carry_nz) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= S_CLAMP_IN;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign ctrl.load = accept;
   assign ctrl.op   = busy_ff ? word.op : OP_NOP;
   assign ctrl.fld  = word.fld;

endmodule

// File: sv/cda_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cda_dp: date/time datapath
// Field registers, reciprocal divider by 60/24/12 and the month-step walker,
// driven one control word per cycle.
// ----------------------------------------------------------------------------
module cda_dp import cda_pkg::*; #(
   parameter int AMOUNT_BITS = DEF_AMOUNT_BITS
) (
   input  logic               clock,
   input  cda_ctrl_type       ctrl,
   input  logic [2:0]         unit,
   input  logic [AMT_W-1:0]   amount,
   input  logic [YEAR_W-1:0]  year_src,
   input  logic [MON_W-1:0]   month_src,
   input  logic [DAY_W-1:0]   day_src,
   input  logic [HR_W-1:0]    hour_src,
   input  logic [MIN_W-1:0]   minute_src,
   input  logic [SEC_W-1:0]   second_src,
   output cda_stat_type       stat,
   output logic [YEAR_W-1:0]  year_res,
   output logic [MON_W-1:0]   month_res,
   output logic [DAY_W-1:0]   day_res,
   output logic [HR_W-1:0]    hour_res,
   output logic [MIN_W-1:0]   minute_res,
   output logic [SEC_W-1:0]   second_res
);

   localparam int AMT_KEEP = (AMOUNT_BITS < AMT_W) ? AMOUNT_BITS : AMT_W;
   localparam logic [AMT_W-1:0] AMT_MASK = AMT_W'((64'd1 << AMT_KEEP) - 1);

   logic [2:0]        unit_ff, unit_in;
   logic [AMT_W-1:0]  amt_ff, amt_in;
   logic [YEAR_W-1:0] yr_ff, yr_in;
   logic [MON_W-1:0]  mo_ff, mo_in;
   logic [DAY_W-1:0]  dy_ff, dy_in;
   logic [HR_W-1:0]   hr_ff, hr_in;
   logic [MIN_W-1:0]  mi_ff, mi_in;
   logic [SEC_W-1:0]  se_ff, se_in;
   logic [T_W-1:0]    carry_ff, carry_in;
   logic [T_W-1:0]    tsum_ff, tsum_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              leap_ff, leap_in;

   logic [DAY_W-1:0]   len;
   logic [T_W-1:0]     base, addend, dconst, qd, r0, rr, dsum;
   logic [RECIP_W-1:0] recip;
   logic [Q_W-1:0]     q0, qq;
   logic [2:0]         own_unit;

   always_comb begin
      len = mon_len(mo_ff, leap_ff);

      unique case (ctrl.fld)
         FLD_SEC:  begin own_unit = UNIT_SEC;  base = T_W'(se_ff); end
         FLD_MIN:  begin own_unit = UNIT_MIN;  base = T_W'(mi_ff); end
         FLD_HOUR: begin own_unit = UNIT_HOUR; base = T_W'(hr_ff); end
         default:  begin own_unit = UNIT_MONTH; base = T_W'(mo_ff - 4'd1); end
      endcase
      unique case (ctrl.fld) inside
         FLD_SEC, FLD_MIN: begin recip = RECIP_60; dconst = SECS_PER_MIN; end
         FLD_HOUR:         begin recip = RECIP_24; dconst = HRS_PER_DAY;  end
         default:          begin recip = RECIP_12; dconst = MONS_PER_YR;  end
      endcase
      // month offset always takes the amount; time fields take the amount
      // only for their own unit, else the carry from below
      addend = ((unit_ff == own_unit) || (ctrl.fld == FLD_MON)) ? T_W'(amt_ff) : carry_ff;

      // quotient estimate is exact or one short; fix with one compare
      q0 = prod_ff[PROD_W-1:FRAC_W];
      qd = T_W'(T_W'(q0) * dconst);
      r0 = tsum_ff - qd;
      if (r0 >= dconst) begin
         rr = r0 - dconst;
         qq = q0 + 1'b1;
      end else begin
         rr = r0;
         qq = q0;
      end

      dsum = T_W'(dy_ff) + carry_ff;

      unit_in  = unit_ff;
      amt_in   = amt_ff;
      yr_in    = yr_ff;
      mo_in    = mo_ff;
      dy_in    = dy_ff;
      hr_in    = hr_ff;
      mi_in    = mi_ff;
      se_in    = se_ff;
      carry_in = carry_ff;
      tsum_in  = tsum_ff;
      prod_in  = prod_ff;

      if (ctrl.load) begin
         unit_in  = unit;
         amt_in   = amount & AMT_MASK;
         yr_in    = year_src;
         mo_in    = (month_src == 4'd0) ? MON_JAN : ((month_src > MON_DEC) ? MON_DEC : month_src);
         dy_in    = (day_src == 5'd0) ? 5'd1 : day_src;
         hr_in    = (hour_src > 5'd23) ? 5'd23 : hour_src;
         mi_in    = (minute_src > 6'd59) ? 6'd59 : minute_src;
         se_in    = (second_src > 6'd59) ? 6'd59 : second_src;
         carry_in = '0;
      end else begin
         unique case (ctrl.op)
            OP_CLAMP: begin
               if (dy_ff > len) dy_in = len;
            end
            OP_MUL: begin
               tsum_in = base + addend;
               prod_in = PROD_W'(tsum_in) * PROD_W'(recip);
            end
            OP_DIV: begin
               unique case (ctrl.fld)
                  FLD_SEC:  begin se_in = rr[SEC_W-1:0]; carry_in = T_W'(qq); end
                  FLD_MIN:  begin mi_in = rr[MIN_W-1:0]; carry_in = T_W'(qq); end
                  FLD_HOUR: begin hr_in = rr[HR_W-1:0];  carry_in = T_W'(qq); end
                  default: begin
                     if (unit_ff == UNIT_MONTH) begin
                        yr_in = yr_ff + YEAR_W'(qq);
                        mo_in = rr[MON_W-1:0] + 4'd1;
                     end
                  end
               endcase
            end
            OP_DAYS: begin
               if (unit_ff == UNIT_DAY) carry_in = T_W'(amt_ff);
            end
            OP_WALK: begin
               if (carry_ff != '0) begin
                  if (dsum > T_W'(len)) begin
                     carry_in = carry_ff - T_W'(len - dy_ff + 5'd1);
                     dy_in    = 5'd1;
                     if (mo_ff == MON_DEC) begin
                        mo_in = MON_JAN;
                        yr_in = yr_ff + 1'b1;
                     end else begin
                        mo_in = mo_ff + 4'd1;
                     end
                  end else begin
                     dy_in    = dsum[DAY_W-1:0];
                     carry_in = '0;
                  end
               end
            end
            default: ;
         endcase
      end

      // leap flag is registered from the year register and trails it, except at load
      leap_in = is_leap(ctrl.load ? year_src : yr_ff);
   end

   always_ff @(posedge clock) begin
      unit_ff  <= unit_in;
      amt_ff   <= amt_in;
      yr_ff    <= yr_in;
      mo_ff    <= mo_in;
      dy_ff    <= dy_in;
      hr_ff    <= hr_in;
      mi_ff    <= mi_in;
      se_ff    <= se_in;
      carry_ff <= carry_in;
      tsum_ff  <= tsum_in;
      prod_ff  <= prod_in;
      leap_ff  <= leap_in;
   end

   assign stat.carry_nz = (carry_ff != '0);
   assign year_res   = yr_ff;
   assign month_res  = mo_ff;
   assign day_res    = dy_ff;
   assign hour_res   = hr_ff;
   assign minute_res = mi_ff;
   assign second_res = se_ff;

endmodule

// File: sv/calendar_datetime_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_datetime_adder: Gregorian date/time adder
// Moves a date and time forward by an amount of seconds, minutes, hours,
// days or months under control of a small microcode program.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_* and raise start; the request is taken at a
//   clock edge where start is high and busy is low. busy then stays high
//   up to the edge that raises rsp_valid.
//   Response channel: rsp_valid is high for exactly one cycle with the moved
//   date and time on rsp_*. The receiver cannot hold it off; capture it then.
//   The rsp_* fields keep their value until the next request is taken.
//   The program clamps the day, ripples carries through seconds, minutes and
//   hours, walks the day carry month by month, adds months and clamps the day
//   again. Each month boundary crossed by the day carry adds a walk step, and
//   one more is added when days remain after the last boundary, so the walk
//   sets how long a request takes. A full 16-bit day amount crosses about 2150
//   months. A new request is taken in the cycle rsp_valid is high.
//   Reset (synchronous, active high) returns the sequencer to idle and drops
//   any request in flight; no result is issued for it.
// ----------------------------------------------------------------------------
module calendar_datetime_adder import cda_pkg::*; #(
   parameter int AMOUNT_BITS = DEF_AMOUNT_BITS
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_unit,
   input  logic [AMT_W-1:0]  req_amount,
   input  logic [YEAR_W-1:0] req_year_in,
   input  logic [MON_W-1:0]  req_month_in,
   input  logic [DAY_W-1:0]  req_day_in,
   input  logic [HR_W-1:0]   req_hour_in,
   input  logic [MIN_W-1:0]  req_minute_in,
   input  logic [SEC_W-1:0]  req_second_in,
   // response channel
   output logic              rsp_valid,
   output logic [YEAR_W-1:0] rsp_year_out,
   output logic [MON_W-1:0]  rsp_month_out,
   output logic [DAY_W-1:0]  rsp_day_out,
   output logic [HR_W-1:0]   rsp_hour_out,
   output logic [MIN_W-1:0]  rsp_minute_out,
   output logic [SEC_W-1:0]  rsp_second_out
);

   cda_ctrl_type ctrl;
   cda_stat_type stat;

   // step counter and control store; loops on the day walk
   cda_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .done  (rsp_valid),
      .ctrl  (ctrl)
   );

   // field registers, divider and month walker; results come straight from
   // the field registers, which hold until the next request loads them
   cda_dp #(
      .AMOUNT_BITS (AMOUNT_BITS)
   ) u_dp (
      .clock      (clock),
      .ctrl       (ctrl),
      .unit       (req_unit),
      .amount     (req_amount),
      .year_src   (req_year_in),
      .month_src  (req_month_in),
      .day_src    (req_day_in),
      .hour_src   (req_hour_in),
      .minute_src (req_minute_in),
      .second_src (req_second_in),
      .stat       (stat),
      .year_res   (rsp_year_out),
      .month_res  (rsp_month_out),
      .day_res    (rsp_day_out),
      .hour_res   (rsp_hour_out),
      .minute_res (rsp_minute_out),
      .second_res (rsp_second_out)
   );

endmodule

// File: bench/tb_calendar_datetime_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_datetime_adder: self-checking bench for the date/time adder
// Drives directed and random requests through the start/busy handshake,
// predicts each moved date and time independently, and compares every
// response field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_calendar_datetime_adder;
   import cda_pkg::*;

   localparam int  CLK_HALF     = 5;
   localparam int  RESET_CYCLES = 10;
   localparam int  STALL_LIMIT  = 20000;   // several times the slowest request
   localparam int  TAIL_CYCLES  = 40;
   localparam int  AMOUNT_BITS  = DEF_AMOUNT_BITS;

   // unit codes with no meaning: the block passes the time through
   localparam logic [2:0] UNIT_SPARE_A = 3'd5;
   localparam logic [2:0] UNIT_SPARE_B = 3'd6;
   localparam logic [2:0] UNIT_SPARE_C = 3'd7;

   localparam int unsigned SECS_IN_MIN  = 60;
   localparam int unsigned MINS_IN_HOUR = 60;
   localparam int unsigned HOURS_IN_DAY = 24;
   localparam int unsigned MONS_IN_YEAR = 12;
   localparam int unsigned YEAR_SPAN    = 1 << YEAR_W;
   localparam int unsigned DAYS_PER_400 = 146097;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [MON_W-1:0]  month;
      logic [DAY_W-1:0]  day;
      logic [HR_W-1:0]   hour;
      logic [MIN_W-1:0]  minute;
      logic [SEC_W-1:0]  second;
   } datetime_type;

   typedef struct packed {
      logic [2:0]       unit;
      logic [AMT_W-1:0] amount;
      datetime_type     start_time;
   } request_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts the moved time for each taken request and checks
   // responses in order.
   // -------------------------------------------------------------------------
   class datetime_scoreboard;
      datetime_type pending_times[$];
      int           errors = 0;

      function int unsigned days_in_month(int unsigned m, int unsigned y);
         bit leap;
         leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
         case (m) inside
            MON_FEB:                            return leap ? 29 : 28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
            default:                            return 31;
         endcase
      endfunction

      function datetime_type advance_datetime(request_type r);
         int unsigned     y, m, d, h, mi, s, len, ylen;
         longint unsigned amt, c, t, total;
         datetime_type    res;
         amt = longint'(r.amount) & ((64'd1 << AMOUNT_BITS) - 1);
         y   = r.start_time.year;
         m   = r.start_time.month;
         d   = r.start_time.day;
         h   = r.start_time.hour;
         mi  = r.start_time.minute;
         s   = r.start_time.second;

         // repair out-of-range starting fields
         if (m < MON_JAN) m = MON_JAN;
         if (m > MON_DEC) m = MON_DEC;
         if (d < 1) d = 1;
         len = days_in_month(m, y);
         if (d > len) d = len;
         if (h > HOURS_IN_DAY - 1) h = HOURS_IN_DAY - 1;
         if (mi > MINS_IN_HOUR - 1) mi = MINS_IN_HOUR - 1;
         if (s > SECS_IN_MIN - 1) s = SECS_IN_MIN - 1;

         // ripple carries from seconds up to days
         c = (r.unit == UNIT_SEC) ? amt : 0;
         t = s + c;  s  = t % SECS_IN_MIN;  c = t / SECS_IN_MIN;
         if (r.unit == UNIT_MIN) c = amt;
         t = mi + c; mi = t % MINS_IN_HOUR; c = t / MINS_IN_HOUR;
         if (r.unit == UNIT_HOUR) c = amt;
         t = h + c;  h  = t % HOURS_IN_DAY; c = t / HOURS_IN_DAY;
         if (r.unit == UNIT_DAY) c = amt;

         // walk the day carry, whole years and 400-year cycles from Jan 1
         while (c > 0) begin
            if (m == MON_JAN && d == 1) begin
               ylen = 337 + days_in_month(MON_FEB, y);
               if (y + 399 <= YEAR_SPAN - 1 && c >= DAYS_PER_400) begin
                  c -= DAYS_PER_400;
                  y  = (y + 400) % YEAR_SPAN;
                  continue;
               end
               if (c >= ylen) begin
                  c -= ylen;
                  y  = (y + 1) % YEAR_SPAN;
                  continue;
               end
            end
            len = days_in_month(m, y);
            if (d + c > len) begin
               c -= len - d + 1;
               d  = 1;
               if (m == MON_DEC) begin
                  m = MON_JAN;
                  y = (y + 1) % YEAR_SPAN;
               end else begin
                  m++;
               end
            end else begin
               d += c;
               c  = 0;
            end
         end

         // month add, then clamp the day to the new month
         if (r.unit == UNIT_MONTH) begin
            total = (m - 1) + amt;
            y     = (y + total / MONS_IN_YEAR) % YEAR_SPAN;
            m     = total % MONS_IN_YEAR + 1;
            len   = days_in_month(m, y);
            if (d > len) d = len;
         end

         res.year   = y;
         res.month  = m;
         res.day    = d;
         res.hour   = h;
         res.minute = mi;
         res.second = s;
         return res;
      endfunction

      function void note_request(request_type r);
         pending_times.push_back(advance_datetime(r));
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(datetime_type got);
         datetime_type want;
         if (pending_times.size() == 0) begin
            $display("%0t: unexpected response %0d-%0d-%0d %0d:%0d:%0d", $time,
                     got.year, got.month, got.day, got.hour, got.minute, got.second);
            errors++;
            return;
         end
         want = pending_times.pop_front();
         compare_field("year",   want.year,   got.year);
         compare_field("month",  want.month,  got.month);
         compare_field("day",    want.day,    got.day);
         compare_field("hour",   want.hour,   got.hour);
         compare_field("minute", want.minute, got.minute);
         compare_field("second", want.second, got.second);
      endfunction

      function int outstanding();
         return pending_times.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and its signals; every input is known from time zero
   // -------------------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [2:0]        req_unit      = '0;
   logic [AMT_W-1:0]  req_amount    = '0;
   logic [YEAR_W-1:0] req_year_in   = '0;
   logic [MON_W-1:0]  req_month_in  = '0;
   logic [DAY_W-1:0]  req_day_in    = '0;
   logic [HR_W-1:0]   req_hour_in   = '0;
   logic [MIN_W-1:0]  req_minute_in = '0;
   logic [SEC_W-1:0]  req_second_in = '0;
   logic              rsp_valid;
   logic [YEAR_W-1:0] rsp_year_out;
   logic [MON_W-1:0]  rsp_month_out;
   logic [DAY_W-1:0]  rsp_day_out;
   logic [HR_W-1:0]   rsp_hour_out;
   logic [MIN_W-1:0]  rsp_minute_out;
   logic [SEC_W-1:0]  rsp_second_out;

   datetime_scoreboard sb = new();
   int                 requests_taken = 0;
   int                 quiet_cycles   = 0;

   calendar_datetime_adder #(.AMOUNT_BITS(AMOUNT_BITS)) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_unit       (req_unit),
      .req_amount     (req_amount),
      .req_year_in    (req_year_in),
      .req_month_in   (req_month_in),
      .req_day_in     (req_day_in),
      .req_hour_in    (req_hour_in),
      .req_minute_in  (req_minute_in),
      .req_second_in  (req_second_in),
      .rsp_valid      (rsp_valid),
      .rsp_year_out   (rsp_year_out),
      .rsp_month_out  (rsp_month_out),
      .rsp_day_out    (rsp_day_out),
      .rsp_hour_out   (rsp_hour_out),
      .rsp_minute_out (rsp_minute_out),
      .rsp_second_out (rsp_second_out)
   );

   always #CLK_HALF clock = ~clock;

   // -------------------------------------------------------------------------
   // Monitor: sample both channels on the rising edge. Check the response
   // first; a new request may be taken in the same cycle and queues behind it.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (rsp_valid) begin
            sb.check_result('{rsp_year_out, rsp_month_out, rsp_day_out,
                              rsp_hour_out, rsp_minute_out, rsp_second_out});
            quiet_cycles = 0;
         end
         if (start && !busy) begin
            sb.note_request('{req_unit, req_amount,
                              '{req_year_in, req_month_in, req_day_in,
                                req_hour_in, req_minute_in, req_second_in}});
            requests_taken++;
            quiet_cycles = 0;
         end
         // watchdog: nothing moved on either channel for too long
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("calendar_datetime_adder test failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driver tasks: all called and returning on a falling edge
   // -------------------------------------------------------------------------
   function automatic request_type make_request(logic [2:0] unit, logic [AMT_W-1:0] amount,
                                                int unsigned y, int unsigned m,
                                                int unsigned d, int unsigned h,
                                                int unsigned mi, int unsigned s);
      request_type r;
      r.unit              = unit;
      r.amount            = amount;
      r.start_time.year   = y;
      r.start_time.month  = m;
      r.start_time.day    = d;
      r.start_time.hour   = h;
      r.start_time.minute = mi;
      r.start_time.second = s;
      return r;
   endfunction

   // Idle the sender per cycle at idle_pct, then hold the request until taken.
   task automatic issue(request_type r, int idle_pct);
      int taken_before;
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_unit      = r.unit;
      req_amount    = r.amount;
      req_year_in   = r.start_time.year;
      req_month_in  = r.start_time.month;
      req_day_in    = r.start_time.day;
      req_hour_in   = r.start_time.hour;
      req_minute_in = r.start_time.minute;
      req_second_in = r.start_time.second;
      start         = 1'b1;
      taken_before  = requests_taken;
      do @(negedge clock); while (requests_taken == taken_before);
   endtask

   // Drop start and hold off until every predicted response has arrived.
   task automatic wait_for_results();
      start = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   // Mostly well-formed times with random content; the rest is raw noise
   // that exercises the input repair and the spare unit codes.
   task automatic run_random(int count, int idle_pct);
      request_type r;
      int unsigned y, m, len;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 85) begin
            case ($urandom_range(3))
               0:       y = $urandom_range(0, YEAR_SPAN - 1);
               1:       y = $urandom_range(1890, 2110);
               2:       y = $urandom_range(YEAR_SPAN - 40, YEAR_SPAN - 1);
               default: y = $urandom_range(0, 800);
            endcase
            m   = $urandom_range(MON_JAN, MON_DEC);
            len = sb.days_in_month(m, y);
            r = make_request($urandom_range(UNIT_SEC, UNIT_MONTH), '0, y, m,
                             ($urandom_range(3) == 0) ? len : $urandom_range(1, len),
                             $urandom_range(0, HOURS_IN_DAY - 1),
                             $urandom_range(0, MINS_IN_HOUR - 1),
                             $urandom_range(0, SECS_IN_MIN - 1));
            // keep long day walks rare; other units take any amount
            if (r.unit == UNIT_DAY)
               r.amount = ($urandom_range(19) == 0) ? $urandom_range(0, YEAR_SPAN - 1)
                                                    : $urandom_range(0, 400);
            else if ($urandom_range(2) == 0)
               r.amount = $urandom_range(0, 100);
            else
               r.amount = $urandom;
         end else begin
            r = make_request($urandom_range(UNIT_SEC, UNIT_SPARE_C), $urandom, $urandom,
                             $urandom_range(0, (1 << MON_W) - 1),
                             $urandom_range(0, (1 << DAY_W) - 1),
                             $urandom_range(0, (1 << HR_W) - 1),
                             $urandom_range(0, (1 << MIN_W) - 1),
                             $urandom_range(0, (1 << SEC_W) - 1));
         end
         issue(r, idle_pct);
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, every unit, leap and wrap corners
      issue(make_request(UNIT_SEC,   16'd0,      0,     1,  1,  0,  0,  0), 0);
      issue(make_request(UNIT_SEC,   16'hFFFF,   65535, 12, 31, 23, 59, 59), 0);
      issue(make_request(UNIT_MIN,   16'hFFFF,   2023,  12, 31, 23, 59, 59), 0);
      issue(make_request(UNIT_MIN,   16'd60,     2023,  6,  30, 23, 0,  0), 0);
      issue(make_request(UNIT_HOUR,  16'hFFFF,   1999,  2,  28, 23, 0,  0), 0);
      issue(make_request(UNIT_HOUR,  16'd1,      2023,  12, 31, 23, 59, 59), 0);
      // longest day walk
      issue(make_request(UNIT_DAY,   16'hFFFF,   2000,  1,  1,  0,  0,  0), 0);
      // leap day present, absent in a plain century, year zero is leap
      issue(make_request(UNIT_DAY,   16'd1,      2024,  2,  28, 12, 0,  0), 0);
      issue(make_request(UNIT_DAY,   16'd1,      2100,  2,  28, 12, 0,  0), 0);
      issue(make_request(UNIT_DAY,   16'd366,    0,     1,  1,  0,  0,  0), 0);
      // year wraps from the top back to zero
      issue(make_request(UNIT_DAY,   16'd1,      65535, 12, 31, 5,  6,  7), 0);
      issue(make_request(UNIT_DAY,   16'd0,      2023,  4,  31, 1,  2,  3), 0);
      // month add with day clamp, in and out of a leap year
      issue(make_request(UNIT_MONTH, 16'd1,      2023,  1,  31, 0,  0,  0), 0);
      issue(make_request(UNIT_MONTH, 16'd1,      2024,  1,  31, 0,  0,  0), 0);
      // month sums that land on a multiple of twelve give December
      issue(make_request(UNIT_MONTH, 16'd12,     2023,  12, 15, 8,  9,  10), 0);
      issue(make_request(UNIT_MONTH, 16'd11,     2023,  1,  31, 8,  9,  10), 0);
      issue(make_request(UNIT_MONTH, 16'hFFFF,   65535, 12, 31, 23, 59, 59), 0);
      issue(make_request(UNIT_MONTH, 16'd0,      2023,  3,  31, 0,  0,  0), 0);
      // spare units and out-of-range starting fields
      issue(make_request(UNIT_SPARE_A, 16'd1234, 2023,  0,  0,  31, 63, 63), 0);
      issue(make_request(UNIT_SPARE_B, 16'hFFFF, 2023,  15, 31, 24, 60, 60), 0);
      issue(make_request(UNIT_SPARE_C, 16'd0,    1900,  2,  31, 5,  5,  5), 0);
      issue(make_request(UNIT_SEC,   16'd1,      2023,  13, 31, 23, 59, 63), 0);

      // random phases: no idling, sender idling, then lighter idling
      run_random(90, 0);
      run_random(45, 48);
      wait_for_results();
      run_random(45, 48);
      run_random(70, 25);

      // drain, then let the block settle before the verdict
      wait_for_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("calendar_datetime_adder test passed");
      else
         $display("calendar_datetime_adder test failed");
      $finish;
   end

endmodule

// File: filelist.f
sv/cda_pkg.sv
sv/cda_seq.sv
sv/cda_dp.sv
sv/calendar_datetime_adder.sv
bench/tb_calendar_datetime_adder.sv
